FILE: design/apr_pkg.sv
// Shared types and constants for the address/port redirect table.
// Used by the controller, the top level and the port checker.
`timescale 1ns / 1ps
`default_nettype none
package apr_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   localparam logic [1:0] CMD_LOOKUP = 2'd0;
   localparam logic [1:0] CMD_ADD    = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [1:0] STAT_FULL      = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] src_ip;
      logic [15:0] src_port;
      logic [31:0] dest_ip;
      logic [15:0] dest_port;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        found;
      logic [31:0] dest_ip;
      logic [15:0] dest_port;
   } res_type;

   typedef struct packed {
      logic [31:0] src_ip;
      logic [15:0] src_port;
      logic [31:0] dest_ip;
      logic [15:0] dest_port;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage
`default_nettype wire

FILE: design/apr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module apr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                         wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

FILE: design/apr_ctrl.sv
// Scan sequencer of the redirect table: walks the entry RAM one slot per
// cycle, keeps the valid bits and applies each command. Uses apr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module apr_ctrl
   import apr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire req_type           req,
   output logic                   idle,
   output logic                   done,
   input  wire logic              take,
   output res_type                res,
   output logic                   ram_we,
   output logic      [IDX_W-1:0]  ram_waddr,
   output entry_type              ram_wdata,
   output logic      [IDX_W-1:0]  ram_raddr,
   input  wire entry_type         ram_rdata
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]         state_ff, state_in;
   req_type            req_ff, req_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]   issue_cnt_ff, issue_cnt_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [31:0]        hit_ip_ff, hit_ip_in;
   logic [15:0]        hit_port_ff, hit_port_in;
   logic               free_ff, free_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   res_type            res_ff, res_in;
   logic               key_match;

   assign idle = (state_ff == S_IDLE);
   assign done = (state_ff == S_DONE);
   assign res  = res_ff;
   assign ram_raddr = issue_cnt_ff[IDX_W-1:0];

   assign key_match = valid_ff[chk_idx_ff] && (ram_rdata.src_ip == req_ff.src_ip)
                      && (ram_rdata.src_port == req_ff.src_port);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      valid_in     = valid_ff;
      issue_cnt_in = issue_cnt_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_ip_in    = hit_ip_ff;
      hit_port_in  = hit_port_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      res_in       = res_ff;
      ram_we       = 1'b0;
      ram_waddr    = free_idx_ff;
      ram_wdata    = '{src_ip: req_ff.src_ip, src_port: req_ff.src_port,
                       dest_ip: req_ff.dest_ip, dest_port: req_ff.dest_port};
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in       = req;
               issue_cnt_in = '0;
               hit_in       = 1'b0;
               free_in      = 1'b0;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            // issue one read per cycle; its data is checked the cycle after
            if (issue_cnt_ff != CNT_W'(ENTRIES)) begin
               issue_cnt_in = issue_cnt_ff + CNT_W'(1);
               chk_vld_in   = 1'b1;
               chk_idx_in   = issue_cnt_ff[IDX_W-1:0];
            end
            if (chk_vld_ff) begin
               if (key_match && !hit_ff) begin
                  hit_in      = 1'b1;
                  hit_idx_in  = chk_idx_ff;
                  hit_ip_in   = ram_rdata.dest_ip;
                  hit_port_in = ram_rdata.dest_port;
               end
               if (!valid_ff[chk_idx_ff] && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = chk_idx_ff;
               end
            end else if (issue_cnt_ff == CNT_W'(ENTRIES)) begin
               // scan complete: apply the command and form the response
               res_in   = '0;
               state_in = S_DONE;
               unique case (req_ff.cmd)
                  CMD_LOOKUP: begin
                     res_in.found = hit_ff;
                     if (hit_ff) begin
                        res_in.dest_ip   = hit_ip_ff;
                        res_in.dest_port = hit_port_ff;
                     end
                  end
                  CMD_ADD: begin
                     if (!hit_ff) begin
                        if (free_ff) begin
                           ram_we                = 1'b1;
                           valid_in[free_idx_ff] = 1'b1;
                        end else begin
                           res_in.status = STAT_FULL;
                        end
                     end
                  end
                  CMD_REMOVE: begin
                     if (hit_ff) begin
                        valid_in[hit_idx_ff] = 1'b0;
                     end else begin
                        res_in.status = STAT_NOT_FOUND;
                     end
                  end
                  CMD_CLEAR: begin
                     valid_in = '0;
                  end
                  default: begin
                     res_in = '0;
                  end
               endcase
            end
         end
         S_DONE: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         valid_ff   <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         chk_vld_ff <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      issue_cnt_ff <= issue_cnt_in;
      chk_idx_ff   <= chk_idx_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      hit_ip_ff    <= hit_ip_in;
      hit_port_ff  <= hit_port_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      res_ff       <= res_in;
   end
endmodule
`default_nettype wire

FILE: design/address_port_redirect_table_core.sv
// Address/port redirect table, top level.
// Instantiates apr_ctrl and apr_ram; uses apr_pkg.
//
// Usage:
//   A request arrives on req_* (tuser carries the command, tdata the key and,
//   for add, the destination). Each request yields exactly one response on
//   rsp_* with the status, a found flag and the matched destination.
//   Entries live in one RAM of ENTRIES slots; every request scans all slots
//   in order, one RAM read per cycle, so the first valid match wins and an
//   add takes the lowest free slot.
//   The time from request to response is set by the one-read-per-cycle
//   scan of the entry RAM, which reads all ENTRIES slots. One request
//   is in work at a time; the next is taken as soon as the scan unit is idle.
//   The response sits in an output register, so a stalled receiver only
//   blocks once a second response is ready and cannot be handed over.
//   Reset clears all valid bits at once; no clearing pass is needed and a
//   request can be taken right after reset. The clear command drops all
//   entries the same way.
`timescale 1ns / 1ps
`default_nettype none
module address_port_redirect_table_core
   import apr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [95:0] req_tdata,  // src_ip[31:0], src_port[47:32],
                                        // dest_ip[79:48], dest_port[95:80]
   input  wire logic [1:0]  req_tuser,  // cmd[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,  // out_dest_ip[31:0], out_dest_port[47:32]
   output logic [2:0]       rsp_tuser   // status[1:0], found[2]
);
   req_type   req;
   res_type   res;
   logic      idle;
   logic      done;
   logic      take;
   logic      start;
   logic      ram_we;
   logic [IDX_W-1:0] ram_waddr;
   logic [IDX_W-1:0] ram_raddr;
   entry_type ram_wdata;
   entry_type ram_rdata;

   logic      rsp_vld_ff, rsp_vld_in;
   res_type   rsp_res_ff, rsp_res_in;

   assign req = '{cmd: req_tuser, src_ip: req_tdata[31:0], src_port: req_tdata[47:32],
                  dest_ip: req_tdata[79:48], dest_port: req_tdata[95:80]};

   assign req_tready = idle;
   assign start      = req_tvalid && idle;
   // hand over the finished response once the output register is free or being read
   assign take       = done && (!rsp_vld_ff || rsp_tready);

   apr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req),
      .idle      (idle),
      .done      (done),
      .take      (take),
      .res       (res),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   apr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      rsp_res_in = rsp_res_ff;
      if (take) begin
         rsp_vld_in = 1'b1;
         rsp_res_in = res;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {rsp_res_ff.dest_port, rsp_res_ff.dest_ip};
   assign rsp_tuser  = {rsp_res_ff.found, rsp_res_ff.status};
endmodule
`default_nettype wire

FILE: design/apr_port_checker.sv
// Port-level checks for the redirect table, bound to the top level.
// Uses apr_pkg for the status codes.
`timescale 1ns / 1ps
`default_nettype none
module apr_port_checker
   import apr_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser
);
   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // only one request in work: no request taken in the cycle after one
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request accepted during scan");

   // a hit always reports ok status
   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tuser[1:0] == STAT_OK)
      else $error("hit with non-ok status");

   // a miss or a non-lookup response carries a zero destination
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[2] |-> rsp_tdata == '0)
      else $error("nonzero destination without a hit");

   // status never takes the unused code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[1:0] == STAT_OK || rsp_tuser[1:0] == STAT_NOT_FOUND
                     || rsp_tuser[1:0] == STAT_FULL)
      else $error("invalid status code");
endmodule

bind address_port_redirect_table_core apr_port_checker u_apr_port_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

FILE: sim/tb_address_port_redirect_table_core.sv
// Self-checking testbench for address_port_redirect_table_core.
// Drives directed and random table commands on req_*, checks rsp_* against
// the typed results of the directed rows or a local copy of the table; uses apr_pkg.
`timescale 1ns / 1ps
module tb_address_port_redirect_table_core;
   import apr_pkg::*;

   localparam int CLK_PERIOD   = 8;
   localparam int CYCLE_LIMIT  = 500_000;
   localparam int SCAN_CYCLES  = ENTRIES + 4;
   localparam int POOL_MAX     = 48;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 275;
   localparam int IDLE_PERCENT = 27;
   localparam int PRINT_CAP    = 100;

   typedef struct packed {
      req_type     req;
      logic        typed;
      res_type     res;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;  // src_ip[31:0], src_port[47:32],
                                 // dest_ip[79:48], dest_port[95:80]
   logic [1:0]  req_tuser = '0;  // cmd[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;       // out_dest_ip[31:0], out_dest_port[47:32]
   logic [2:0]  rsp_tuser;       // status[1:0], found[2]

   // local copy of the redirect table
   logic      tbl_valid [ENTRIES];
   entry_type tbl_entry [ENTRIES];

   res_type   redirect_expect [$];
   int        error_count = 0;
   int        rsp_count = 0;
   bit        steady = 1'b0;

   logic [31:0] key_ip_pool   [POOL_MAX];
   logic [15:0] key_port_pool [POOL_MAX];

   // directed rows; typed results are the ones plain from the command semantics
   directed_row_type dir_rows [11] = '{
      '{'{CMD_LOOKUP, 32'hffff_ffff, 16'hffff, 32'h0, 16'h0}, 1'b1,
        '{STAT_OK, 1'b0, 32'h0, 16'h0}},
      '{'{CMD_REMOVE, 32'hffff_ffff, 16'hffff, 32'h0, 16'h0}, 1'b1,
        '{STAT_NOT_FOUND, 1'b0, 32'h0, 16'h0}},
      '{'{CMD_ADD, 32'h0, 16'h0, 32'hffff_ffff, 16'hffff}, 1'b1,
        '{STAT_OK, 1'b0, 32'h0, 16'h0}},
      '{'{CMD_ADD, 32'hffff_ffff, 16'hffff, 32'h0, 16'h0}, 1'b1,
        '{STAT_OK, 1'b0, 32'h0, 16'h0}},
      '{'{CMD_ADD, 32'h0, 16'hffff, 32'h1234_5678, 16'habcd}, 1'b1,
        '{STAT_OK, 1'b0, 32'h0, 16'h0}},
      '{'{CMD_LOOKUP, 32'h0, 16'h0, 32'h5555_5555, 16'h5555}, 1'b1,
        '{STAT_OK, 1'b1, 32'hffff_ffff, 16'hffff}},
      '{'{CMD_LOOKUP, 32'hffff_ffff, 16'hffff, 32'h0, 16'h0}, 1'b1,
        '{STAT_OK, 1'b1, 32'h0, 16'h0}},
      '{'{CMD_ADD, 32'h0, 16'h0, 32'h1111_1111, 16'h2222}, 1'b1,
        '{STAT_OK, 1'b0, 32'h0, 16'h0}},
      '{'{CMD_LOOKUP, 32'h0, 16'h0, 32'h0, 16'h0}, 1'b1,
        '{STAT_OK, 1'b1, 32'hffff_ffff, 16'hffff}},
      '{'{CMD_REMOVE, 32'h0, 16'h0, 32'h0, 16'h0}, 1'b1,
        '{STAT_OK, 1'b0, 32'h0, 16'h0}},
      '{'{CMD_LOOKUP, 32'hffff_ffff, 16'h0, 32'h0, 16'h0}, 1'b1,
        '{STAT_OK, 1'b0, 32'h0, 16'h0}}
   };

   int pool_sizes   [PHASES] = '{20, 40, 6, 24, 48, 18};
   int clear_rates  [PHASES] = '{5, 30, 5, 10, 5, 60};  // per thousand

   address_port_redirect_table_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   task automatic report_mismatch(input string what);
      if (error_count < PRINT_CAP) begin
         $display("%0t ns: response %0d: %s", $time, rsp_count, what);
      end
      error_count++;
   endtask

   // Apply one command to the local table and return the response it causes.
   function automatic res_type predict_redirect(input req_type r);
      res_type res;
      int      hit;
      int      spare;
      int      i;
      res   = '0;
      hit   = -1;
      spare = -1;
      for (i = 0; i < ENTRIES; i++) begin
         if (hit < 0 && tbl_valid[i] && tbl_entry[i].src_ip == r.src_ip &&
             tbl_entry[i].src_port == r.src_port) begin
            hit = i;
         end
         if (spare < 0 && !tbl_valid[i]) begin
            spare = i;
         end
      end
      case (r.cmd)
         CMD_LOOKUP: begin
            if (hit >= 0) begin
               res.found     = 1'b1;
               res.dest_ip   = tbl_entry[hit].dest_ip;
               res.dest_port = tbl_entry[hit].dest_port;
            end
         end
         CMD_ADD: begin
            // a present key keeps its old destination
            if (hit < 0) begin
               if (spare < 0) begin
                  res.status = STAT_FULL;
               end else begin
                  tbl_valid[spare] = 1'b1;
                  tbl_entry[spare] = '{r.src_ip, r.src_port, r.dest_ip, r.dest_port};
               end
            end
         end
         CMD_REMOVE: begin
            if (hit < 0) begin
               res.status = STAT_NOT_FOUND;
            end else begin
               tbl_valid[hit] = 1'b0;
            end
         end
         CMD_CLEAR: begin
            for (i = 0; i < ENTRIES; i++) begin
               tbl_valid[i] = 1'b0;
            end
         end
      endcase
      return res;
   endfunction

   // Hold the request until it is taken; queue its expected response.
   task automatic send_request(input req_type r, input logic typed, input res_type typed_res);
      res_type want;
      @(negedge clock);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.cmd;
      req_tdata  <= {r.dest_port, r.dest_ip, r.src_port, r.src_ip};
      do @(posedge clock); while (req_tready !== 1'b1);
      want = predict_redirect(r);
      redirect_expect.insert(redirect_expect.size(), typed ? typed_res : want);
   endtask

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      res_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         rsp_count++;
         if (redirect_expect.size() == 0) begin
            report_mismatch("response with no request pending");
         end else begin
            want = redirect_expect.pop_front();
            if (rsp_tuser[1:0] !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_tuser[1:0], want.status));
            if (rsp_tuser[2] !== want.found)
               report_mismatch($sformatf("found %0b, expected %0b",
                                         rsp_tuser[2], want.found));
            if (rsp_tdata[31:0] !== want.dest_ip)
               report_mismatch($sformatf("dest_ip %h, expected %h",
                                         rsp_tdata[31:0], want.dest_ip));
            if (rsp_tdata[47:32] !== want.dest_port)
               report_mismatch($sformatf("dest_port %h, expected %h",
                                         rsp_tdata[47:32], want.dest_port));
         end
      end
   end

   initial begin
      #(CLK_PERIOD * CYCLE_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      req_type r;
      int      i;
      int      ph;
      int      n;
      int      k;
      int      op;
      for (i = 0; i < ENTRIES; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_entry[i] = '0;
      end
      // odd pool keys share the address of their neighbor, differing in port only
      for (i = 0; i < POOL_MAX; i++) begin
         key_ip_pool[i]   = (i % 2 == 1) ? key_ip_pool[i - 1] : $urandom;
         key_port_pool[i] = 16'($urandom);
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < $size(dir_rows); i++) begin
         send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
      end
      // fill the remaining slots, overflow once, then look up the first new key
      n = 0;
      for (i = 0; i < ENTRIES; i++) begin
         if (!tbl_valid[i]) n++;
      end
      for (i = 0; i <= n; i++) begin
         r = '{CMD_ADD, 32'(32'hc0a8_0000 + i), 16'(16'h1f90 + i), $urandom,
               16'($urandom)};
         send_request(r, 1'b0, '0);
      end
      r = '{CMD_LOOKUP, 32'hc0a8_0000, 16'h1f90, 32'h0, 16'h0};
      send_request(r, 1'b0, '0);
      r = '{CMD_CLEAR, 32'hdead_beef, 16'hbeef, 32'hffff_ffff, 16'hffff};
      send_request(r, 1'b1, '{STAT_OK, 1'b0, 32'h0, 16'h0});

      for (ph = 0; ph < PHASES; ph++) begin
         steady = (ph == 2);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(99) < 85) begin
               k = $urandom_range(pool_sizes[ph] - 1);
               r.src_ip   = key_ip_pool[k];
               r.src_port = key_port_pool[k];
            end else begin
               r.src_ip   = $urandom;
               r.src_port = 16'($urandom);
            end
            r.dest_ip   = $urandom;
            r.dest_port = 16'($urandom);
            op = $urandom_range(999);
            if (op < clear_rates[ph])
               r.cmd = CMD_CLEAR;
            else if (op < 350)
               r.cmd = CMD_LOOKUP;
            else if (op < 720)
               r.cmd = CMD_ADD;
            else
               r.cmd = CMD_REMOVE;
            send_request(r, 1'b0, '0);
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b0;
      steady = 1'b0;

      while (redirect_expect.size() != 0) @(posedge clock);
      repeat (2 * SCAN_CYCLES) @(posedge clock);
      if (error_count == 0 && redirect_expect.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
